@@ rtl/d2pc_pkg.sv @@
// shared widths, codes and record types for the depth to point cloud block
package d2pc_pkg;

  localparam int DEPTH_W  = 20;
  localparam int COLOR_W  = 8;
  localparam int COORD_W  = 28;
  localparam int FOCAL_W  = 24;
  localparam int SIZE_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  // magnitude of 2*pos-(n-1) for frames up to 16384 wide
  localparam int MAG_W    = 15;
  localparam int PROD_W   = DEPTH_W + MAG_W;
  localparam int SPLIT_W  = 18;
  localparam int LO_W     = SPLIT_W + FOCAL_W;
  localparam int HI_W     = PROD_W - SPLIT_W + FOCAL_W;
  localparam int FULL_W   = PROD_W + FOCAL_W;
  localparam int FRAC_SH  = 25;
  localparam int QUO_W    = FULL_W - FRAC_SH;

  localparam int DEFAULT_MAX_COLS = 4096;
  localparam int DEFAULT_MAX_ROWS = 4096;

  // queue between classifier and arithmetic
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // reset values of the registers
  localparam logic [SIZE_W-1:0]  RST_FRAME_COLS = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]  RST_FRAME_ROWS = SIZE_W'(480);
  localparam logic [FOCAL_W-1:0] RST_INV_FOCAL  = FOCAL_W'(30268);
  localparam logic [DEPTH_W-1:0] RST_CUTOFF     = DEPTH_W'(6400);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COLS   = 3'd0,
    REG_FRAME_ROWS   = 3'd1,
    REG_INV_FOCAL    = 3'd2,
    REG_CUTOFF_DEPTH = 3'd3,
    REG_COLOR_MODE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    COLOR_NONE = 2'd0,
    COLOR_MONO = 2'd1,
    COLOR_RGB  = 2'd2
  } color_mode_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  frame_cols;
    logic [SIZE_W-1:0]  frame_rows;
    logic [FOCAL_W-1:0] inv_focal;
    logic [DEPTH_W-1:0] cutoff_depth;
    logic [1:0]         color_mode;
  } cfg_t;

  // one classified pixel as it travels through the queue
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               valid;
    logic               x_neg;
    logic [MAG_W-1:0]   x_mag;
    logic               y_neg;
    logic [MAG_W-1:0]   y_mag;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               frame_end;
    logic               frame_dense;
  } pixel_rec_t;

endpackage

@@ rtl/d2pc_front.sv @@
// front end: pixel position counters, validity and colour selection
module d2pc_front #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  d2pc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [d2pc_pkg::DEPTH_W-1:0]  depth_value,
  input  logic [d2pc_pkg::COLOR_W-1:0]  red_or_grey,
  input  logic [d2pc_pkg::COLOR_W-1:0]  green_byte,
  input  logic [d2pc_pkg::COLOR_W-1:0]  blue_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output d2pc_pkg::pixel_rec_t          q_rec
);
  import d2pc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = MAG_W + 1;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic          dense_so_far;

  logic [EW-1:0] cols_eff;
  logic [EW-1:0] rows_eff;
  logic          row_last;
  logic          frame_last;
  logic          pix_valid;
  logic          dense;
  logic signed [EW:0] x_off;
  logic signed [EW:0] y_off;
  logic signed [EW:0] x_abs;
  logic signed [EW:0] y_abs;
  logic          accept;

  // effective frame size: zero acts as one, clamp to the maximum
  always_comb begin
    if (cfg.frame_cols == '0) begin
      cols_eff = EW'(1);
    end else if (EW'(cfg.frame_cols) > EW'(MAX_COLS)) begin
      cols_eff = EW'(MAX_COLS);
    end else begin
      cols_eff = EW'(cfg.frame_cols);
    end
    if (cfg.frame_rows == '0) begin
      rows_eff = EW'(1);
    end else if (EW'(cfg.frame_rows) > EW'(MAX_ROWS)) begin
      rows_eff = EW'(MAX_ROWS);
    end else begin
      rows_eff = EW'(cfg.frame_rows);
    end
  end

  // position classification
  assign row_last   = (EW'(col_count) + EW'(1)) >= cols_eff;
  assign frame_last = row_last && ((EW'(row_count) + EW'(1)) >= rows_eff);
  assign pix_valid  = depth_value > cfg.cutoff_depth;
  assign dense      = pix_valid & dense_so_far;

  // signed offsets 2*pos-(n-1) split into sign and magnitude
  assign x_off = $signed({1'b0, EW'({col_count, 1'b0})}) - $signed({1'b0, cols_eff - EW'(1)});
  assign y_off = $signed({1'b0, EW'({row_count, 1'b0})}) - $signed({1'b0, rows_eff - EW'(1)});
  assign x_abs = x_off[EW] ? -x_off : x_off;
  assign y_abs = y_off[EW] ? -y_off : y_off;

  assign accept   = in_valid & ~q_full;
  assign in_stall = q_full;
  assign q_push   = accept;

  // record for the back end
  always_comb begin
    q_rec.depth       = depth_value;
    q_rec.valid       = pix_valid;
    q_rec.x_neg       = x_off[EW];
    q_rec.x_mag       = x_abs[MAG_W-1:0];
    q_rec.y_neg       = y_off[EW];
    q_rec.y_mag       = y_abs[MAG_W-1:0];
    q_rec.frame_end   = frame_last;
    q_rec.frame_dense = frame_last & dense;
    case (color_mode_t'(cfg.color_mode))
      COLOR_MONO: begin
        q_rec.red   = red_or_grey;
        q_rec.green = red_or_grey;
        q_rec.blue  = red_or_grey;
      end
      COLOR_RGB: begin
        q_rec.red   = red_or_grey;
        q_rec.green = green_byte;
        q_rec.blue  = blue_byte;
      end
      default: begin
        q_rec.red   = '0;
        q_rec.green = '0;
        q_rec.blue  = '0;
      end
    endcase
  end

  // raster counters and running dense flag
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count    <= '0;
      row_count    <= '0;
      dense_so_far <= 1'b1;
    end else if (accept) begin
      if (frame_last) begin
        col_count    <= '0;
        row_count    <= '0;
        dense_so_far <= 1'b1;
      end else if (row_last) begin
        col_count    <= '0;
        row_count    <= row_count + RW'(1);
        dense_so_far <= dense;
      end else begin
        col_count    <= col_count + CW'(1);
        dense_so_far <= dense;
      end
    end
  end

endmodule

@@ rtl/d2pc_queue.sv @@
// short fifo of classified pixels between front and back end
module d2pc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  d2pc_pkg::pixel_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output d2pc_pkg::pixel_rec_t pop_rec
);
  import d2pc_pkg::*;

  pixel_rec_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_rec   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/d2pc_back.sv @@
// back end: three stage projection pipeline with output register
module d2pc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [d2pc_pkg::FOCAL_W-1:0]        inv_focal,
  input  logic                                q_not_empty,
  input  d2pc_pkg::pixel_rec_t                q_rec,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [d2pc_pkg::COORD_W-1:0] point_x,
  output logic signed [d2pc_pkg::COORD_W-1:0] point_y,
  output logic [d2pc_pkg::DEPTH_W-1:0]        point_z,
  output logic                                point_valid,
  output logic [d2pc_pkg::COLOR_W-1:0]        out_red,
  output logic [d2pc_pkg::COLOR_W-1:0]        out_green,
  output logic [d2pc_pkg::COLOR_W-1:0]        out_blue,
  output logic                                frame_end,
  output logic                                frame_dense
);
  import d2pc_pkg::*;

  localparam logic [QUO_W-1:0] SAT_MAG_POS = QUO_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [QUO_W-1:0] SAT_MAG_NEG = QUO_W'(64'd1 << (COORD_W - 1));

  // round to nearest, ties away from zero, then sign and saturate
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic [LO_W-1:0] lo,
    input logic [HI_W-1:0] hi,
    input logic            neg
  );
    logic [FULL_W-1:0]        sum;
    logic [QUO_W-1:0]         quo;
    logic signed [COORD_W-1:0] res;
    sum = FULL_W'(lo) + (FULL_W'(hi) << SPLIT_W) + (FULL_W'(1) << (FRAC_SH - 1));
    quo = sum[FULL_W-1:FRAC_SH];
    if (neg) begin
      if (quo > SAT_MAG_NEG) begin
        res = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        res = -$signed(quo[COORD_W-1:0]);
      end
    end else begin
      if (quo > SAT_MAG_POS) begin
        res = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        res = $signed(quo[COORD_W-1:0]);
      end
    end
    return res;
  endfunction

  logic              advance;
  logic              s1_valid;
  pixel_rec_t        s1_rec;
  logic [PROD_W-1:0] s1_px;
  logic [PROD_W-1:0] s1_py;
  logic              s2_valid;
  pixel_rec_t        s2_rec;
  logic [LO_W-1:0]   s2_x_lo;
  logic [HI_W-1:0]   s2_x_hi;
  logic [LO_W-1:0]   s2_y_lo;
  logic [HI_W-1:0]   s2_y_hi;
  logic signed [COORD_W-1:0] x_res;
  logic signed [COORD_W-1:0] y_res;

  // whole pipeline moves unless a finished result is held by the receiver
  assign advance = ~(out_valid & out_stall);
  assign q_pop   = advance & q_not_empty;

  assign x_res = round_sat(s2_x_lo, s2_x_hi, s2_rec.x_neg);
  assign y_res = round_sat(s2_y_lo, s2_y_hi, s2_rec.y_neg);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= q_not_empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // stage 1: depth times offset magnitude
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rec <= q_rec;
      s1_px  <= PROD_W'(q_rec.depth) * PROD_W'(q_rec.x_mag);
      s1_py  <= PROD_W'(q_rec.depth) * PROD_W'(q_rec.y_mag);
    end
  end

  // stage 2: split partial products with the focal reciprocal
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_rec  <= s1_rec;
      s2_x_lo <= LO_W'(s1_px[SPLIT_W-1:0]) * LO_W'(inv_focal);
      s2_x_hi <= HI_W'(s1_px[PROD_W-1:SPLIT_W]) * HI_W'(inv_focal);
      s2_y_lo <= LO_W'(s1_py[SPLIT_W-1:0]) * LO_W'(inv_focal);
      s2_y_hi <= HI_W'(s1_py[PROD_W-1:SPLIT_W]) * HI_W'(inv_focal);
    end
  end

  // stage 3: sum, round, saturate into the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      point_x     <= s2_rec.valid ? x_res : '0;
      point_y     <= s2_rec.valid ? y_res : '0;
      point_z     <= s2_rec.valid ? s2_rec.depth : '0;
      point_valid <= s2_rec.valid;
      out_red     <= s2_rec.red;
      out_green   <= s2_rec.green;
      out_blue    <= s2_rec.blue;
      frame_end   <= s2_rec.frame_end;
      frame_dense <= s2_rec.frame_dense;
    end
  end

endmodule

@@ rtl/depth_to_point_cloud.sv @@
// top level: configuration registers, front end, queue and projection back end
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    depth_value, red_or_grey, green_byte, blue_byte
//   out      source     out_valid / out_stall  point_x/y/z, point_valid, out_red/green/blue,
//                                              frame_end, frame_dense
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one pixel per clock sustained while out_stall stays low; a taken pixel is written into
// the queue, then passes the two multiplier stages, the second of which feeds the
// rounding into the output register.
// rst is synchronous and clears counters, queue and stage valid bits; registers take
// their documented defaults. out_stall freezes the back end; the four entry queue then
// fills and raises in_stall. cfg_ready is always high.
module depth_to_point_cloud #(
  parameter int MAX_COLS = d2pc_pkg::DEFAULT_MAX_COLS,
  parameter int MAX_ROWS = d2pc_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [d2pc_pkg::DEPTH_W-1:0]        depth_value,
  input  logic [d2pc_pkg::COLOR_W-1:0]        red_or_grey,
  input  logic [d2pc_pkg::COLOR_W-1:0]        green_byte,
  input  logic [d2pc_pkg::COLOR_W-1:0]        blue_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [d2pc_pkg::COORD_W-1:0] point_x,
  output logic signed [d2pc_pkg::COORD_W-1:0] point_y,
  output logic [d2pc_pkg::DEPTH_W-1:0]        point_z,
  output logic                                point_valid,
  output logic [d2pc_pkg::COLOR_W-1:0]        out_red,
  output logic [d2pc_pkg::COLOR_W-1:0]        out_green,
  output logic [d2pc_pkg::COLOR_W-1:0]        out_blue,
  output logic                                frame_end,
  output logic                                frame_dense,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [d2pc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [d2pc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import d2pc_pkg::*;

  cfg_t       cfg;
  logic       q_full;
  logic       q_push;
  pixel_rec_t q_in_rec;
  logic       q_pop;
  logic       q_not_empty;
  pixel_rec_t q_out_rec;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_cols   <= RST_FRAME_COLS;
      cfg.frame_rows   <= RST_FRAME_ROWS;
      cfg.inv_focal    <= RST_INV_FOCAL;
      cfg.cutoff_depth <= RST_CUTOFF;
      cfg.color_mode   <= COLOR_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_COLS:   cfg.frame_cols   <= cfg_data[SIZE_W-1:0];
        REG_FRAME_ROWS:   cfg.frame_rows   <= cfg_data[SIZE_W-1:0];
        REG_INV_FOCAL:    cfg.inv_focal    <= cfg_data[FOCAL_W-1:0];
        REG_CUTOFF_DEPTH: cfg.cutoff_depth <= cfg_data[DEPTH_W-1:0];
        REG_COLOR_MODE:   cfg.color_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // classification of incoming pixels
  d2pc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .depth_value (depth_value),
    .red_or_grey (red_or_grey),
    .green_byte  (green_byte),
    .blue_byte   (blue_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_rec       (q_in_rec)
  );

  // decoupling queue
  d2pc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (q_in_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_rec   (q_out_rec)
  );

  // projection arithmetic
  d2pc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .inv_focal   (cfg.inv_focal),
    .q_not_empty (q_not_empty),
    .q_rec       (q_out_rec),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_valid (point_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .frame_end   (frame_end),
    .frame_dense (frame_dense)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench for the depth to point cloud block
module tb_top;
  import d2pc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [FOCAL_W-1:0] FOCAL_MAX = '1;
  localparam longint unsigned SAT_HI = 64'd134217727;
  localparam longint unsigned SAT_LO_MAG = 64'd134217728;

  // one back-projected point as it leaves the block
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DEPTH_W-1:0] pz;
    logic               pvalid;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               f_end;
    logic               f_dense;
  } point_rec_t;

  // pinhole back-projection predictor and queue of points still owed
  class point_scoreboard;
    logic [SIZE_W-1:0]  cols_reg;
    logic [SIZE_W-1:0]  rows_reg;
    logic [FOCAL_W-1:0] focal;
    logic [DEPTH_W-1:0] cutoff;
    logic [1:0]         mode;
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    bit                 dense_acc;
    point_rec_t         expected_points[$];
    int                 errors;

    function new();
      cols_reg  = RST_FRAME_COLS;
      rows_reg  = RST_FRAME_ROWS;
      focal     = RST_INV_FOCAL;
      cutoff    = RST_CUTOFF;
      mode      = COLOR_NONE;
      col_cnt   = 0;
      row_cnt   = 0;
      dense_acc = 1'b1;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_COLS:   cols_reg = val[SIZE_W-1:0];
        REG_FRAME_ROWS:   rows_reg = val[SIZE_W-1:0];
        REG_INV_FOCAL:    focal = val[FOCAL_W-1:0];
        REG_CUTOFF_DEPTH: cutoff = val[DEPTH_W-1:0];
        REG_COLOR_MODE:   mode = val[1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize acts as the maximum
    function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return v;
    endfunction

    // depth * (2*pos - (n-1)) * inv_focal / 2^25, rounded half away from zero, saturated
    function logic [COORD_W-1:0] lateral(logic [DEPTH_W-1:0] depth, int unsigned pos,
                                         int unsigned n);
      longint          offset;
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned quo;
      offset = 2 * longint'(pos) - (longint'(n) - 1);
      mag = (offset < 0) ? longint'(-offset) : longint'(offset);
      prod = longint'(depth) * mag * longint'(focal);
      quo = (prod + (64'd1 << 24)) >> 25;
      if (offset < 0) begin
        if (quo > SAT_LO_MAG) return {1'b1, {(COORD_W-1){1'b0}}};
        return COORD_W'(-longint'(quo));
      end
      if (quo > SAT_HI) return {1'b0, {(COORD_W-1){1'b1}}};
      return COORD_W'(quo);
    endfunction

    function void note_pixel(logic [DEPTH_W-1:0] depth, logic [COLOR_W-1:0] r,
                             logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
      int unsigned cols;
      int unsigned rows;
      bit          good;
      bit          row_last;
      bit          frame_last;
      bit          dense;
      point_rec_t  p;
      cols = clamp_size(cols_reg, DEFAULT_MAX_COLS);
      rows = clamp_size(rows_reg, DEFAULT_MAX_ROWS);
      good = depth > cutoff;
      row_last = col_cnt + 1 >= cols;
      frame_last = row_last && (row_cnt + 1 >= rows);
      p = '0;
      if (good) begin
        p.px = lateral(depth, col_cnt, cols);
        p.py = lateral(depth, row_cnt, rows);
        p.pz = depth;
        p.pvalid = 1'b1;
      end
      // unused mode falls through to no colour
      case (mode)
        COLOR_MONO: begin
          p.red = r;
          p.green = r;
          p.blue = r;
        end
        COLOR_RGB: begin
          p.red = r;
          p.green = g;
          p.blue = b;
        end
        default: ;
      endcase
      dense = good && dense_acc;
      p.f_end = frame_last;
      p.f_dense = frame_last && dense;
      // advance raster position
      if (frame_last) begin
        col_cnt = 0;
        row_cnt = 0;
        dense_acc = 1'b1;
      end else if (row_last) begin
        col_cnt = 0;
        row_cnt = row_cnt + 1;
        dense_acc = dense;
      end else begin
        col_cnt = col_cnt + 1;
        dense_acc = dense;
      end
      expected_points = {expected_points, p};
    endfunction

    function void cmp(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_point(point_rec_t got);
      point_rec_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x %0d y %0d z %0d",
                 $time, $signed(got.px), $signed(got.py), got.pz);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      cmp("point_x", longint'($signed(want.px)), longint'($signed(got.px)));
      cmp("point_y", longint'($signed(want.py)), longint'($signed(got.py)));
      cmp("point_z", longint'(want.pz), longint'(got.pz));
      cmp("point_valid", longint'(want.pvalid), longint'(got.pvalid));
      cmp("out_red", longint'(want.red), longint'(got.red));
      cmp("out_green", longint'(want.green), longint'(got.green));
      cmp("out_blue", longint'(want.blue), longint'(got.blue));
      cmp("frame_end", longint'(want.f_end), longint'(got.f_end));
      cmp("frame_dense", longint'(want.f_dense), longint'(got.f_dense));
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DEPTH_W-1:0]    depth_value = '0;
  logic [COLOR_W-1:0]    red_or_grey = '0;
  logic [COLOR_W-1:0]    green_byte = '0;
  logic [COLOR_W-1:0]    blue_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [DEPTH_W-1:0]    point_z;
  logic                  point_valid;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic                  frame_end;
  logic                  frame_dense;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  point_scoreboard sb;
  point_rec_t      got_point;
  bit              in_quiet = 1'b0;
  bit              out_quiet = 1'b0;
  int              stall_hold = 0;
  int              idle_cycles = 0;
  bit              progress;

  depth_to_point_cloud dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .depth_value(depth_value), .red_or_grey(red_or_grey),
    .green_byte(green_byte), .blue_byte(blue_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .point_valid(point_valid),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .frame_end(frame_end), .frame_dense(frame_dense),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly short, now and then long
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
    return $urandom_range(8, 40);
  endfunction

  // depth below, at or above the cutoff
  function automatic logic [DEPTH_W-1:0] rand_depth(logic [DEPTH_W-1:0] cut,
                                                    int unsigned bad_pct);
    if (cut == DEPTH_MAX || $urandom_range(0, 99) < bad_pct) begin
      if ($urandom_range(0, 3) == 0) return cut;
      return DEPTH_W'($urandom_range(0, cut));
    end
    case ($urandom_range(0, 7))
      0: return cut + 1'b1;
      1: return DEPTH_MAX;
      default: return DEPTH_W'($urandom_range(cut + 1, DEPTH_MAX));
    endcase
  endfunction

  // receiver stalls in random on/off stretches
  always @(negedge clk) begin
    if (rst || out_quiet) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = pick_len();
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      if (out_valid && !out_stall) begin
        got_point = '{point_x, point_y, point_z, point_valid, out_red, out_green,
                      out_blue, frame_end, frame_dense};
        sb.check_point(got_point);
        progress = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_pixel(depth_value, red_or_grey, green_byte, blue_byte);
        progress = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    int gap;
    gap = (in_quiet || $urandom_range(0, 3) != 0) ? 0 : pick_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    depth_value <= d;
    red_or_grey <= r;
    green_byte <= g;
    blue_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_pixel(input logic [DEPTH_W-1:0] d);
    send_pixel(d, COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
               COLOR_W'($urandom_range(0, 255)));
  endtask

  task automatic write_one(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // let the pipeline drain, then rewrite every register
  task automatic configure(input logic [SIZE_W-1:0] cols, input logic [SIZE_W-1:0] rows,
                           input logic [FOCAL_W-1:0] focal, input logic [DEPTH_W-1:0] cut,
                           input logic [1:0] mode);
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_one(REG_FRAME_COLS, CFG_DATA_W'(cols));
    write_one(REG_FRAME_ROWS, CFG_DATA_W'(rows));
    write_one(REG_INV_FOCAL, CFG_DATA_W'(focal));
    write_one(REG_CUTOFF_DEPTH, CFG_DATA_W'(cut));
    write_one(REG_COLOR_MODE, CFG_DATA_W'(mode));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0]  cols;
    logic [SIZE_W-1:0]  rows;
    logic [FOCAL_W-1:0] focal;
    logic [DEPTH_W-1:0] cut;
    logic [1:0]         mode;
    int unsigned        bad_pct;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults after reset: cutoff boundary, no colour
    send_pixel(20'd6400, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(20'd6401, 8'h5A, 8'hA5, 8'h3C);
    send_pixel(DEPTH_MAX, 8'h00, 8'h00, 8'h00);

    // 2x2 frames in mono: invalid at zero cutoff, then a dense frame, then a sparse one
    configure(13'd2, 13'd2, FOCAL_MAX, 20'd0, COLOR_MONO);
    send_pixel(20'd0, 8'hFF, 8'h00, 8'h00);
    send_pixel(DEPTH_MAX, 8'h00, 8'hFF, 8'hFF);
    send_pixel(20'd1, 8'hA5, 8'h5A, 8'h00);
    send_pixel(DEPTH_MAX, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(20'd1, 8'h01, 8'h80, 8'h7F);
    send_pixel(20'h80000, 8'h80, 8'h01, 8'hFE);
    send_pixel(20'h7FFFF, 8'h7F, 8'hFE, 8'h01);
    send_pixel(DEPTH_MAX, 8'h55, 8'hAA, 8'h55);
    send_pixel(DEPTH_MAX, 8'hAA, 8'h55, 8'hAA);
    send_pixel(20'd2, 8'h0F, 8'hF0, 8'h0F);
    send_pixel(20'd0, 8'hF0, 8'h0F, 8'hF0);

    // zero width single row frames, nothing above the cutoff, unused colour mode
    configure(13'd0, 13'd1, 24'd1, DEPTH_MAX, 2'd3);
    send_pixel(DEPTH_MAX, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(20'd0, 8'hFF, 8'hFF, 8'hFF);

    // oversize frame, then shrink it mid-row; halves round away from zero
    configure(13'h1FFF, 13'h1FFF, 24'd1, 20'd0, COLOR_RGB);
    send_pixel(DEPTH_MAX, 8'hFF, 8'h00, 8'hFF);
    send_pixel(20'hFFFF0, 8'h00, 8'hFF, 8'h00);
    send_pixel(20'd3, 8'h12, 8'h34, 8'h56);
    configure(13'd2, 13'd1, 24'h800000, 20'd0, COLOR_RGB);
    send_pixel(20'd2, 8'h9A, 8'hBC, 8'hDE);
    send_pixel(20'd2, 8'hFE, 8'hDC, 8'hBA);

    // random settings, mostly small frames so that frames end often
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        0: cols = 13'd0;
        1: cols = 13'h1FFF;
        2: cols = 13'd4096;
        default: cols = SIZE_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0: rows = 13'd0;
        1: rows = 13'h1FFF;
        2: rows = 13'd4096;
        default: rows = SIZE_W'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 3))
        0: focal = FOCAL_MAX;
        1: focal = 24'd1;
        default: focal = FOCAL_W'($urandom_range(1, FOCAL_MAX));
      endcase
      case ($urandom_range(0, 9))
        0: cut = 20'd0;
        1: cut = DEPTH_MAX;
        default: cut = DEPTH_W'($urandom_range(0, 20'h3FFFF));
      endcase
      mode = 2'($urandom_range(0, 3));
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      configure(cols, rows, focal, cut, mode);
      bad_pct = ($urandom_range(0, 2) == 0) ? 0 : 8;
      repeat (30) send_random_pixel(rand_depth(cut, bad_pct));
    end

    // tall single column frame at full focal gain: y saturates at both ends
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    configure(13'd1, 13'd258, FOCAL_MAX, 20'd0, COLOR_RGB);
    repeat (258) begin
      if ($urandom_range(0, 1) == 0)
        send_random_pixel(DEPTH_MAX - DEPTH_W'($urandom_range(0, 12'hFFF)));
      else
        send_random_pixel(DEPTH_W'($urandom_range(0, DEPTH_MAX)));
    end

    // wait for the last points, then report
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
